/* rtl/hvn_pkg.sv */
// ----------------------------------------------------------------------------
// hvn_pkg
// Shared widths, face and command/status types for the vertex normal block.
// ----------------------------------------------------------------------------
package hvn_pkg;

  localparam int HEIGHT_W = 16;  // Q8.8 height sample
  localparam int CFG_W    = 9;   // grid size register
  localparam int FACE_W   = 17;  // difference of two heights
  localparam int SUM_W    = 19;  // sum of up to four face parts
  localparam int MAG_W    = 18;  // magnitude of a summed component
  localparam int SQ_W     = 2 * MAG_W;
  localparam int LEN_W    = SQ_W + 2;  // sum of three squares
  localparam int REM_W    = LEN_W + 1;
  localparam int Q_W      = 29;  // floor(m^2 * 2^28 / len2) <= 2^28
  localparam int K_W      = 15;  // unit component magnitude <= 16384
  localparam int NORM_W   = 16;
  localparam int VTX_W    = 8;
  localparam int CNT_W    = 5;
  localparam int BIT_W    = 4;

  localparam int Q_STEPS  = Q_W;
  localparam int K_STEPS  = K_W;
  localparam int Y_SHIFT  = 8;   // y part of one face is 256

  localparam logic [1:0] COMP_X = 2'd0;
  localparam logic [1:0] COMP_Y = 2'd1;
  localparam logic [1:0] COMP_Z = 2'd2;

  typedef struct packed {
    logic signed [FACE_W-1:0] x;
    logic signed [FACE_W-1:0] z;
  } hvn_face_t;

  typedef struct packed {
    logic             take;       // input transfer: latch item, advance counters
    logic             face;       // build face of this column, write face store
    logic             sum;        // add the touching faces
    logic             sel;        // 0: vertex of row above, 1: vertex of last row
    logic             sq;         // square one component
    logic [1:0]       comp;
    logic             len;        // squared length
    logic             dload;      // start division for comp
    logic             div_step;
    logic             sqrt_step;
    logic [BIT_W-1:0] bit_idx;
    logic             store;      // keep signed unit component
    logic             out_load;
    logic             shift;      // current column becomes left column
  } hvn_cmd_t;

  typedef struct packed {
    logic has_result;  // next item yields a normal
    logic lastrow;     // latched item lies in the last row
    logic out_free;    // output register can take a result
  } hvn_status_t;

endpackage

/* rtl/hvn_in_if.sv */
// ----------------------------------------------------------------------------
// hvn_in_if
// Height sample channel: valid/ready plus one signed Q8.8 height.
// ----------------------------------------------------------------------------
interface hvn_in_if;
  logic                              valid;
  logic                              ready;
  logic signed [hvn_pkg::HEIGHT_W-1:0] height;

  modport source (output valid, output height, input ready);
  modport sink   (input valid, input height, output ready);
endinterface

/* rtl/hvn_out_if.sv */
// ----------------------------------------------------------------------------
// hvn_out_if
// Vertex normal channel: valid/ready plus the unit normal and its vertex.
// ----------------------------------------------------------------------------
interface hvn_out_if;
  logic                                valid;
  logic                                ready;
  logic signed [hvn_pkg::NORM_W-1:0]   normal_x;
  logic        [hvn_pkg::K_W-1:0]      normal_y;
  logic signed [hvn_pkg::NORM_W-1:0]   normal_z;
  logic        [hvn_pkg::VTX_W-1:0]    vertex_row;
  logic        [hvn_pkg::VTX_W-1:0]    vertex_col;
  logic                                run_last;
  logic                                map_done;

  modport source (output valid, output normal_x, output normal_y, output normal_z,
                  output vertex_row, output vertex_col, output run_last,
                  output map_done, input ready);
  modport sink   (input valid, input normal_x, input normal_y, input normal_z,
                  input vertex_row, input vertex_col, input run_last,
                  input map_done, output ready);
endinterface

/* rtl/hvn_ctrl.sv */
// ----------------------------------------------------------------------------
// hvn_ctrl
// Sequencer: steps the datapath through sum, squares, divide and root.
// ----------------------------------------------------------------------------
module hvn_ctrl (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  hvn_pkg::hvn_status_t st_i,
  output hvn_pkg::hvn_cmd_t    cmd_o
);
  import hvn_pkg::*;

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_READ  = 4'd1;
  localparam logic [3:0] S_SUM   = 4'd2;
  localparam logic [3:0] S_SQ    = 4'd3;
  localparam logic [3:0] S_LEN   = 4'd4;
  localparam logic [3:0] S_DLOAD = 4'd5;
  localparam logic [3:0] S_DIV   = 4'd6;
  localparam logic [3:0] S_SQRT  = 4'd7;
  localparam logic [3:0] S_STORE = 4'd8;
  localparam logic [3:0] S_OUT   = 4'd9;

  logic [3:0]       state_q, state_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic [1:0]       comp_q, comp_d;
  logic             sel_q, sel_d;

  always_comb begin
    state_d    = state_q;
    cnt_d      = cnt_q;
    comp_d     = comp_q;
    sel_d      = sel_q;
    cmd_o      = '0;
    cmd_o.sel  = sel_q;
    cmd_o.comp = comp_q;
    in_ready_o = 1'b0;
    case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.take = 1'b1;
          if (st_i.has_result) begin
            state_d = S_READ;
          end
        end
      end
      S_READ: begin
        cmd_o.face = 1'b1;
        sel_d      = 1'b0;
        state_d    = S_SUM;
      end
      S_SUM: begin
        cmd_o.sum = 1'b1;
        cnt_d     = '0;
        state_d   = S_SQ;
      end
      S_SQ: begin
        cmd_o.sq   = 1'b1;
        cmd_o.comp = cnt_q[1:0];
        if (cnt_q[1:0] == COMP_Z) begin
          comp_d  = COMP_X;
          state_d = S_LEN;
        end else begin
          cnt_d = cnt_q + 1'b1;
        end
      end
      S_LEN: begin
        cmd_o.len = 1'b1;
        state_d   = S_DLOAD;
      end
      S_DLOAD: begin
        cmd_o.dload = 1'b1;
        cnt_d       = '0;
        state_d     = S_DIV;
      end
      S_DIV: begin
        cmd_o.div_step = 1'b1;
        if (cnt_q == CNT_W'(Q_STEPS - 1)) begin
          cnt_d   = '0;
          state_d = S_SQRT;
        end else begin
          cnt_d = cnt_q + 1'b1;
        end
      end
      S_SQRT: begin
        cmd_o.sqrt_step = 1'b1;
        cmd_o.bit_idx   = BIT_W'(K_STEPS - 1) - cnt_q[BIT_W-1:0];
        if (cnt_q == CNT_W'(K_STEPS - 1)) begin
          state_d = S_STORE;
        end else begin
          cnt_d = cnt_q + 1'b1;
        end
      end
      S_STORE: begin
        cmd_o.store = 1'b1;
        if (comp_q == COMP_Z) begin
          state_d = S_OUT;
        end else begin
          comp_d  = comp_q + 1'b1;
          state_d = S_DLOAD;
        end
      end
      S_OUT: begin
        if (st_i.out_free) begin
          cmd_o.out_load = 1'b1;
          if (!sel_q && st_i.lastrow) begin
            sel_d   = 1'b1;
            state_d = S_SUM;
          end else begin
            cmd_o.shift = 1'b1;
            state_d     = S_IDLE;
          end
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      cnt_q   <= '0;
      comp_q  <= COMP_X;
      sel_q   <= 1'b0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      comp_q  <= comp_d;
      sel_q   <= sel_d;
    end
  end

endmodule

/* rtl/hvn_datapath.sv */
// ----------------------------------------------------------------------------
// hvn_datapath
// Row stores, face sums, squared length, restoring divider, root search.
// ----------------------------------------------------------------------------
module hvn_datapath #(
  parameter int MAX_GRID = 256
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 cfg_we_i,
  input  logic [hvn_pkg::CFG_W-1:0]            cfg_wdata_i,
  input  logic signed [hvn_pkg::HEIGHT_W-1:0]  in_height_i,
  input  logic                                 out_ready_i,
  input  hvn_pkg::hvn_cmd_t                    cmd_i,
  output hvn_pkg::hvn_status_t                 st_o,
  output logic                                 out_valid_o,
  output logic signed [hvn_pkg::NORM_W-1:0]    normal_x_o,
  output logic        [hvn_pkg::K_W-1:0]       normal_y_o,
  output logic signed [hvn_pkg::NORM_W-1:0]    normal_z_o,
  output logic        [hvn_pkg::VTX_W-1:0]     vertex_row_o,
  output logic        [hvn_pkg::VTX_W-1:0]     vertex_col_o,
  output logic                                 run_last_o,
  output logic                                 map_done_o
);
  import hvn_pkg::*;

  localparam int AW     = $clog2(MAX_GRID);
  localparam int GW     = (AW + 1 > CFG_W) ? AW + 1 : CFG_W;
  localparam int FDEPTH = 2 ** (AW + 1);

  // grid size and position
  logic [CFG_W-1:0] grid_q;
  logic [GW-1:0]    g_eff, grid_ext, c_inc, r_inc;
  logic [AW-1:0]    row_q, col_q, col_p1;
  logic             bank_q;

  assign grid_ext = GW'(grid_q);
  always_comb begin
    if (grid_ext < GW'(2)) begin
      g_eff = GW'(2);
    end else if (grid_ext > GW'(MAX_GRID)) begin
      g_eff = GW'(MAX_GRID);
    end else begin
      g_eff = grid_ext;
    end
  end
  assign c_inc  = GW'(col_q) + 1'b1;
  assign r_inc  = GW'(row_q) + 1'b1;
  assign col_p1 = AW'(c_inc);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      grid_q <= CFG_W'(256);
      row_q  <= '0;
      col_q  <= '0;
      bank_q <= 1'b0;
    end else if (cfg_we_i) begin
      grid_q <= cfg_wdata_i;
      row_q  <= '0;
      col_q  <= '0;
    end else if (cmd_i.take) begin
      if (c_inc >= g_eff) begin
        col_q <= '0;
        if (row_q != '0) begin
          bank_q <= ~bank_q;
        end
        row_q <= (r_inc >= g_eff) ? '0 : AW'(r_inc);
      end else begin
        col_q <= AW'(c_inc);
      end
    end
  end

  // item registers
  logic signed [HEIGHT_W-1:0] item_h_q;
  logic [AW-1:0] item_r_q, item_c_q;
  logic is_r2_q, last_q, right_q, left_q, done_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.take) begin
      item_h_q <= in_height_i;
      item_r_q <= row_q;
      item_c_q <= col_q;
      is_r2_q  <= (row_q > AW'(1));
      last_q   <= (GW'(row_q) == g_eff - 1'b1);
      done_q   <= (GW'(col_q) == g_eff - 1'b1);
      right_q  <= (c_inc < g_eff);
      left_q   <= (col_q != '0);
    end
  end

  // previous height row: read at c and c+1, write c
  logic signed [HEIGHT_W-1:0] hmem [MAX_GRID];
  logic signed [HEIGHT_W-1:0] hp_a_q, hp_b_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.take) begin
      hp_a_q      <= hmem[col_q];
      hp_b_q      <= hmem[col_p1];
      hmem[col_q] <= in_height_i;
    end
  end

  // face rows, two banks: write current row, read the row above
  hvn_face_t fmem [FDEPTH];
  hvn_face_t fp_q, face_d, cc_q, cl_q, pl_q;

  assign face_d.x = FACE_W'(hp_a_q) - FACE_W'(hp_b_q);
  assign face_d.z = FACE_W'(hp_a_q) - FACE_W'(item_h_q);

  always_ff @(posedge clk_i) begin
    if (cmd_i.take) begin
      fp_q <= fmem[{~bank_q, col_q}];
    end
    if (cmd_i.face && right_q) begin
      fmem[{bank_q, item_c_q}] <= face_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.face) begin
      cc_q <= face_d;
    end
    if (cmd_i.shift) begin
      cl_q <= cc_q;
      pl_q <= fp_q;
    end
  end

  // sum of touching faces
  logic use_p;
  logic signed [SUM_W-1:0] sx_d, sz_d, ax, az;
  logic [2:0]              nface;
  logic [MAG_W-1:0]        my_d;

  assign use_p = !cmd_i.sel && is_r2_q;
  always_comb begin
    sx_d  = '0;
    sz_d  = '0;
    nface = '0;
    if (use_p && left_q) begin
      sx_d  = sx_d + SUM_W'(pl_q.x);
      sz_d  = sz_d + SUM_W'(pl_q.z);
      nface = nface + 1'b1;
    end
    if (use_p && right_q) begin
      sx_d  = sx_d + SUM_W'(fp_q.x);
      sz_d  = sz_d + SUM_W'(fp_q.z);
      nface = nface + 1'b1;
    end
    if (left_q) begin
      sx_d  = sx_d + SUM_W'(cl_q.x);
      sz_d  = sz_d + SUM_W'(cl_q.z);
      nface = nface + 1'b1;
    end
    if (right_q) begin
      sx_d  = sx_d + SUM_W'(cc_q.x);
      sz_d  = sz_d + SUM_W'(cc_q.z);
      nface = nface + 1'b1;
    end
  end
  assign ax   = sx_d[SUM_W-1] ? -sx_d : sx_d;
  assign az   = sz_d[SUM_W-1] ? -sz_d : sz_d;
  assign my_d = MAG_W'(nface) << Y_SHIFT;

  logic [MAG_W-1:0] mag_q [3];
  logic             neg_x_q, neg_z_q;
  logic [SQ_W-1:0]  sq_q [3];
  logic [LEN_W-1:0] len_q;
  logic [SQ_W-1:0]  prod;

  assign prod = SQ_W'(mag_q[cmd_i.comp]) * SQ_W'(mag_q[cmd_i.comp]);

  always_ff @(posedge clk_i) begin
    if (cmd_i.sum) begin
      mag_q[COMP_X] <= MAG_W'(ax);
      mag_q[COMP_Y] <= my_d;
      mag_q[COMP_Z] <= MAG_W'(az);
      neg_x_q       <= sx_d[SUM_W-1];
      neg_z_q       <= sz_d[SUM_W-1];
    end
    if (cmd_i.sq) begin
      sq_q[cmd_i.comp] <= prod;
    end
    if (cmd_i.len) begin
      len_q <= LEN_W'(sq_q[COMP_X]) + LEN_W'(sq_q[COMP_Y]) + LEN_W'(sq_q[COMP_Z]);
    end
  end

  // q = floor(m^2 * 2^28 / len2), one quotient bit per cycle;
  // then k = floor(sqrt(q)), one result bit per cycle
  logic [REM_W-1:0] rem_q, diff;
  logic [Q_W-1:0]   q_q;
  logic [K_W-1:0]   k_q, cand;
  logic [2*K_W-1:0] cand2;
  logic             ge;

  assign diff  = rem_q - REM_W'(len_q);
  assign ge    = (rem_q >= REM_W'(len_q));
  assign cand  = k_q | (K_W'(1) << cmd_i.bit_idx);
  assign cand2 = (2 * K_W)'(cand) * (2 * K_W)'(cand);

  always_ff @(posedge clk_i) begin
    if (cmd_i.dload) begin
      rem_q <= REM_W'(sq_q[cmd_i.comp]);
      q_q   <= '0;
      k_q   <= '0;
    end else if (cmd_i.div_step) begin
      rem_q <= ge ? {diff[REM_W-2:0], 1'b0} : {rem_q[REM_W-2:0], 1'b0};
      q_q   <= {q_q[Q_W-2:0], ge};
    end else if (cmd_i.sqrt_step) begin
      if (cand2 <= (2 * K_W)'(q_q)) begin
        k_q <= cand;
      end
    end
  end

  logic [NORM_W-1:0] kx;
  logic              kneg;
  logic [NORM_W-1:0] res_q [3];

  assign kx   = NORM_W'(k_q);
  assign kneg = (cmd_i.comp == COMP_X) ? neg_x_q :
                (cmd_i.comp == COMP_Z) ? neg_z_q : 1'b0;

  always_ff @(posedge clk_i) begin
    if (cmd_i.store) begin
      res_q[cmd_i.comp] <= kneg ? (NORM_W'(0) - kx) : kx;
    end
  end

  // output register
  logic out_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.out_load) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      normal_x_o   <= res_q[COMP_X];
      normal_y_o   <= res_q[COMP_Y][K_W-1:0];
      normal_z_o   <= res_q[COMP_Z];
      vertex_row_o <= cmd_i.sel ? VTX_W'(item_r_q) : VTX_W'(item_r_q - 1'b1);
      vertex_col_o <= VTX_W'(item_c_q);
      run_last_o   <= cmd_i.sel | ~last_q;
      map_done_o   <= cmd_i.sel & done_q;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign st_o.has_result = (row_q != '0);
  assign st_o.lastrow    = last_q;
  assign st_o.out_free   = !out_valid_q || out_ready_i;

endmodule

/* rtl/heightmap_vertex_normals.sv */
// ----------------------------------------------------------------------------
// heightmap_vertex_normals
// Unit vertex normals (Q1.14) of a square Q8.8 heightmap streamed in raster
// order.
// ----------------------------------------------------------------------------
// A first-row height is only stored and gives no normal. Each normal takes a
// face sum, 3 squares, a length, per component a load, 29 divider steps, 15
// root steps and a store, then an output load; transfer and face read come
// first. A last-row item yields two normals; each output load stalls while
// the normal waits. No height is taken until an item's last normal is loaded.
// Reset: grid size 256, counters at zero, output empty; row stores hold
// garbage until written, which the raster order always does first.
// ----------------------------------------------------------------------------
module heightmap_vertex_normals #(
  parameter int MAX_GRID = 256
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_we_i,
  input  logic [hvn_pkg::CFG_W-1:0]   cfg_wdata_i,
  hvn_in_if.sink                      in_i,
  hvn_out_if.source                   out_o
);
  import hvn_pkg::*;

  hvn_cmd_t    cmd;
  hvn_status_t st;
  logic        in_ready;

  // Controller: sequences each item through its normals.
  hvn_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_i.valid),
    .in_ready_o (in_ready),
    .st_i       (st),
    .cmd_o      (cmd)
  );

  assign in_i.ready = in_ready;

  // Datapath: row stores, arithmetic and the output register.
  hvn_datapath #(
    .MAX_GRID (MAX_GRID)
  ) u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .in_height_i  (in_i.height),
    .out_ready_i  (out_o.ready),
    .cmd_i        (cmd),
    .st_o         (st),
    .out_valid_o  (out_o.valid),
    .normal_x_o   (out_o.normal_x),
    .normal_y_o   (out_o.normal_y),
    .normal_z_o   (out_o.normal_z),
    .vertex_row_o (out_o.vertex_row),
    .vertex_col_o (out_o.vertex_col),
    .run_last_o   (out_o.run_last),
    .map_done_o   (out_o.map_done)
  );

endmodule

/* bench/hvn_normal_checker.sv */
// ----------------------------------------------------------------------------
// hvn_normal_checker
// Watches the height and normal channels, predicts each vertex normal and
// compares transfers field by field against the oldest prediction.
// ----------------------------------------------------------------------------
module hvn_normal_checker #(
  parameter int MAX_GRID = 256
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      cfg_we_i,
  input  logic [hvn_pkg::CFG_W-1:0] cfg_wdata_i,
  hvn_in_if                         in_i,
  hvn_out_if                        out_i,
  output int                        pending_o,
  output int                        fail_count_o
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic signed [15:0] nx;
    logic        [14:0] ny;
    logic signed [15:0] nz;
    logic        [7:0]  row;
    logic        [7:0]  col;
    logic               run_last;
    logic               map_done;
  } vertex_normal_t;

  vertex_normal_t normals_due[$];

  logic [hvn_pkg::CFG_W-1:0] grid_reg = 9'd256;
  int unsigned row_pos = 0;
  int unsigned col_pos = 0;
  int          height_row [MAX_GRID];
  int          face_above_x [MAX_GRID];
  int          face_above_z [MAX_GRID];
  int          face_cur_x [MAX_GRID];
  int          face_cur_z [MAX_GRID];
  int          fails = 0;

  assign pending_o    = normals_due.size();
  assign fail_count_o = fails;

  function automatic int unsigned grid_eff();
    if (grid_reg < 2) return 2;
    if (grid_reg > MAX_GRID) return MAX_GRID;
    return grid_reg;
  endfunction

  // floor(16384*|c|/sqrt(len2)), found one bit at a time; the square wraps at 64 bits
  function automatic logic [15:0] unit_comp(int c, bit [63:0] len2);
    bit [63:0] mag;
    bit [63:0] sq;
    bit [63:0] k;
    bit [63:0] cand;
    mag = (c < 0) ? 64'(-c) : 64'(c);
    mag = mag << 14;
    sq  = mag * mag;
    k   = 0;
    for (int b = 14; b >= 0; b--) begin
      cand = k | (64'd1 << b);
      if (sq / (cand * cand) >= len2) k = cand;
    end
    return (c < 0) ? -k[15:0] : k[15:0];
  endfunction

  // sum the faces left and right of column c in the chosen face rows
  function automatic vertex_normal_t vertex_normal(bit use_above, bit use_cur,
                                                   int unsigned vr, int unsigned vc,
                                                   int unsigned g, bit last, bit done);
    vertex_normal_t v;
    int sx;
    int sy;
    int sz;
    bit [63:0] len2;
    logic [15:0] y;
    sx = 0; sy = 0; sz = 0;
    if (use_above) begin
      if (vc >= 1) begin
        sx += face_above_x[vc-1]; sz += face_above_z[vc-1]; sy += 256;
      end
      if (vc + 1 < g) begin
        sx += face_above_x[vc]; sz += face_above_z[vc]; sy += 256;
      end
    end
    if (use_cur) begin
      if (vc >= 1) begin
        sx += face_cur_x[vc-1]; sz += face_cur_z[vc-1]; sy += 256;
      end
      if (vc + 1 < g) begin
        sx += face_cur_x[vc]; sz += face_cur_z[vc]; sy += 256;
      end
    end
    len2 = 64'(longint'(sx) * sx) + 64'(longint'(sy) * sy) + 64'(longint'(sz) * sz);
    y = unit_comp(sy, len2);
    v.nx = unit_comp(sx, len2);
    v.ny = y[14:0];
    v.nz = unit_comp(sz, len2);
    v.row = vr[7:0];
    v.col = vc[7:0];
    v.run_last = last;
    v.map_done = done;
    return v;
  endfunction

  function automatic void take_height(logic signed [15:0] hs);
    int unsigned g;
    int unsigned r;
    int unsigned c;
    int h;
    bit lastrow;
    g = grid_eff();
    r = row_pos;
    c = col_pos;
    h = hs;
    if (r >= g || c >= g) begin
      r = 0; c = 0;
    end
    if (r >= 1) begin
      lastrow = (r == g - 1);
      if (c + 1 < g) begin
        face_cur_x[c] = height_row[c] - height_row[c+1];
        face_cur_z[c] = height_row[c] - h;
      end
      normals_due.push_back(vertex_normal(r >= 2, 1'b1, r - 1, c, g, !lastrow, 1'b0));
      // the bottom vertex sees only the face row just built
      if (lastrow)
        normals_due.push_back(vertex_normal(1'b0, 1'b1, r, c, g, 1'b1, c == g - 1));
    end
    height_row[c] = h;
    c++;
    if (c >= g) begin
      c = 0;
      if (r >= 1) begin
        face_above_x = face_cur_x;
        face_above_z = face_cur_z;
      end
      r++;
      if (r >= g) r = 0;
    end
    row_pos = r;
    col_pos = c;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    vertex_normal_t want;
    vertex_normal_t got;
    if (!rst_ni) begin
      grid_reg = 9'd256;
      row_pos  = 0;
      col_pos  = 0;
      normals_due.delete();
    end else begin
      if (cfg_we_i) begin
        grid_reg = cfg_wdata_i;
        row_pos  = 0;
        col_pos  = 0;
      end
      if (in_i.valid && in_i.ready) take_height(in_i.height);
      if (out_i.valid && out_i.ready) begin
        got = '{out_i.normal_x, out_i.normal_y, out_i.normal_z, out_i.vertex_row,
                out_i.vertex_col, out_i.run_last, out_i.map_done};
        if (normals_due.size() == 0) begin
          fails++;
          if (fails <= 10)
            $display("%0t: unexpected normal x=%0d y=%0d z=%0d at (%0d,%0d)", $realtime,
                     got.nx, got.ny, got.nz, got.row, got.col);
        end else begin
          want = normals_due.pop_front();
          if (got !== want) begin
            fails++;
            if (fails <= 10)
              $display("%0t: normal mismatch exp x=%0d y=%0d z=%0d v=(%0d,%0d) l=%0b d=%0b",
                       $realtime, want.nx, want.ny, want.nz, want.row, want.col,
                       want.run_last, want.map_done, "\n            got x=%0d y=%0d z=%0d ",
                       got.nx, got.ny, got.nz, "v=(%0d,%0d) l=%0b d=%0b", got.row,
                       got.col, got.run_last, got.map_done);
          end
        end
      end
    end
  end

endmodule

/* bench/tb_heightmap_vertex_normals.sv */
// ----------------------------------------------------------------------------
// tb_heightmap_vertex_normals
// Streams square heightmaps of many sizes into the vertex normal block under
// random sender gaps and receiver stalls; the checker judges every normal.
// ----------------------------------------------------------------------------
module tb_heightmap_vertex_normals;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int IDLE_LIMIT  = 12000;  // cycles without any transfer
  localparam int DRAIN_WAIT  = 400;    // longer than a last-row item takes
  localparam int HOLD_CYCLES = 3000;   // long receiver hold-off

  logic                      clk_i = 1'b0;
  logic                      rst_ni = 1'b0;
  logic                      cfg_we = 1'b0;
  logic [hvn_pkg::CFG_W-1:0] cfg_wdata = '0;
  int                        pending;
  int                        fail_count;
  int                        items_sent = 0;
  int                        hold_requests = 0;
  int                        burst_left = 0;

  hvn_in_if  in_ch ();
  hvn_out_if out_ch ();

  initial begin
    in_ch.valid   = 1'b0;
    in_ch.height  = '0;
    out_ch.ready  = 1'b0;
  end

  always #6 clk_i = ~clk_i;

  heightmap_vertex_normals uut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we),
    .cfg_wdata_i(cfg_wdata),
    .in_i       (in_ch),
    .out_o      (out_ch)
  );

  hvn_normal_checker chk (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we),
    .cfg_wdata_i (cfg_wdata),
    .in_i        (in_ch),
    .out_i       (out_ch),
    .pending_o   (pending),
    .fail_count_o(fail_count)
  );

  // Receiver: phases of always-ready, light and heavy stalling; a hold-off
  // request drops ready for a long stretch so the block backs up.
  int hold_seen = 0;
  int hold_left = 0;
  int phase_left = 0;
  int phase_mode = 0;
  always @(posedge clk_i) begin
    if (hold_requests != hold_seen) begin
      hold_seen = hold_requests;
      hold_left = HOLD_CYCLES;
    end
    if (phase_left == 0) begin
      phase_left = $urandom_range(400, 20);
      phase_mode = $urandom_range(2, 0);
    end
    phase_left--;
    if (hold_left > 0) begin
      hold_left--;
      out_ch.ready <= 1'b0;
    end else begin
      case (phase_mode)
        0: out_ch.ready <= 1'b1;
        1: out_ch.ready <= ($urandom_range(9, 0) < 7);
        default: out_ch.ready <= ($urandom_range(9, 0) < 2);
      endcase
    end
  end

  // Watchdog: end the run when nothing transfers for too long.
  int idle_cycles = 0;
  always @(posedge clk_i) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
      idle_cycles = 0;
    else if (rst_ni)
      idle_cycles++;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  task automatic wait_drained();
    while (pending != 0) @(posedge clk_i);
  endtask

  // Lower valid and sit out a gap.
  task automatic sender_gap(int cycles);
    in_ch.valid <= 1'b0;
    repeat (cycles) @(posedge clk_i);
  endtask

  // Offer one height, hold it until the transfer, with bursty gaps between.
  task automatic send_height(logic signed [15:0] h);
    if (burst_left == 0) begin
      burst_left = $urandom_range(30, 1);
      if ($urandom_range(3, 0) != 0) sender_gap($urandom_range(40, 1));
    end
    burst_left--;
    in_ch.valid  <= 1'b1;
    in_ch.height <= h;
    @(posedge clk_i);
    while (!in_ch.ready) @(posedge clk_i);
    items_sent++;
  endtask

  // Write grid_size only with the block idle: drain, then let it settle.
  task automatic write_grid(logic [hvn_pkg::CFG_W-1:0] value);
    sender_gap(1);
    wait_drained();
    repeat (DRAIN_WAIT) @(posedge clk_i);
    cfg_we    <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk_i);
    cfg_we    <= 1'b0;
    burst_left = 0;
  endtask

  // Heights: smooth terrain, wild full-range samples, or extremes only.
  function automatic logic signed [15:0] pick_height(int style, logic signed [15:0] last);
    case (style)
      0: return last + 16'($signed($urandom_range(1024, 0)) - 512);
      1: return 16'($urandom);
      default: return $urandom_range(1, 0) ? 16'sh7fff : 16'sh8000;
    endcase
  endfunction

  task automatic feed_heights(int count, int style);
    logic signed [15:0] h;
    h = 16'($urandom);
    for (int i = 0; i < count; i++) begin
      h = pick_height(style, h);
      send_height(h);
    end
  endtask

  initial begin
    int g;
    int maps;
    bit hold_done;
    bit pause_done;
    hold_done  = 1'b0;
    pause_done = 1'b0;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: smallest grid with opposing extremes, a flat map, clamped
    // sizes below two, a new map begun mid-row, then a 3x3 of extremes.
    write_grid(9'd2);
    send_height(16'sh7fff); send_height(16'sh8000);
    send_height(16'sh8000); send_height(16'sh7fff);
    repeat (4) send_height(16'sh0000);
    write_grid(9'd0);
    send_height(16'sh8000); send_height(16'sh8000);
    send_height(16'sh7fff); send_height(16'sh0001);
    write_grid(9'd1);
    send_height(16'sh1234); send_height(16'shedcb); send_height(16'sh7fff);
    write_grid(9'd3);
    feed_heights(9, 2);

    // Largest grids: just over one row each; values above the maximum clamp.
    write_grid(9'd511);
    feed_heights(256 + 8, 1);
    write_grid(9'd256);
    feed_heights(256 + 5, 0);

    // Random: mostly complete small maps, some cut short by a rewrite.
    while (items_sent < 1150) begin
      g = ($urandom_range(9, 0) == 0) ? $urandom_range(20, 13) : $urandom_range(12, 2);
      write_grid(g[8:0]);
      maps = $urandom_range(2, 1);
      for (int m = 0; m < maps && items_sent < 1150; m++) begin
        if (!hold_done && items_sent > 700) begin
          hold_requests++;
          hold_done = 1'b1;
        end
        if ($urandom_range(7, 0) == 0) begin
          feed_heights($urandom_range(g * g - 1, 1), $urandom_range(2, 0));
          break;
        end
        feed_heights(g * g / 2, $urandom_range(1, 0));
        if (!pause_done || $urandom_range(9, 0) == 0) begin
          sender_gap(1);
          wait_drained();
          pause_done = 1'b1;
        end
        feed_heights(g * g - g * g / 2, $urandom_range(1, 0));
      end
    end

    sender_gap(1);
    wait_drained();
    repeat (DRAIN_WAIT) @(posedge clk_i);
    if (fail_count == 0 && pending == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

/* filelist.f */
rtl/hvn_pkg.sv
rtl/hvn_in_if.sv
rtl/hvn_out_if.sv
rtl/hvn_ctrl.sv
rtl/hvn_datapath.sv
rtl/heightmap_vertex_normals.sv
bench/hvn_normal_checker.sv
bench/tb_heightmap_vertex_normals.sv
